FILE: src/session_token_table_macros.svh
// Assertion macros for the session token table.
`ifndef SESSION_TOKEN_TABLE_MACROS_SVH
`define SESSION_TOKEN_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// Check that an antecedent implies a consequent in the same cycle.
`define STT_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("session table check failed");
// Check that an antecedent implies a consequent in the next cycle.
`define STT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("session table check failed");
`else
`define STT_ASSERT_IMPLY(lbl, ante, cons)
`define STT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/stt_pkg.sv
// Shared types, codes and constants for the session token table.
package stt_pkg;

    localparam int SESSIONS_DEF = 4;
    localparam int PIN_CHARS    = 8;
    localparam int CFG_AW       = 5;
    localparam int CFG_DW       = 64;

    localparam logic [63:0] MIX_GOLDEN = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL_A  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94D0_49BB_1331_11EB;
    localparam int          MIX_SH_A   = 30;
    localparam int          MIX_SH_B   = 27;
    localparam int          MIX_SH_C   = 31;

    typedef enum logic [1:0] {
        ACT_UNLOCK   = 2'd0,
        ACT_VALIDATE = 2'd1,
        ACT_REMAIN   = 2'd2,
        ACT_ANY      = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_PIN     = 2'd0,
        REG_PIN_LEN = 2'd1,
        REG_TIMEOUT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [63:0] pin_code;
        logic [3:0]  pin_code_len;
        logic [31:0] session_timeout;
    } t_cfg;

    typedef struct packed {
        t_action     action;
        logic [31:0] now_ms;
        logic [63:0] pin;
        logic [3:0]  pin_length;
        logic [63:0] entropy;
        logic [63:0] token;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [63:0] token_out;
        logic [31:0] remaining_ms;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_MIX_GO,
        ST_MIX_WAIT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MX_IDLE,
        MX_GOLD,
        MX_MUL1,
        MX_MUL2
    } t_mix_state;

endpackage

FILE: src/session_token_table.sv
// Session token table top level: request sequencer, slot memories and config port.
// Order of steps: a failed unlock goes straight from acceptance to the result.
// Validate, remaining time, any active: one read and one check per slot, then the result.
// Successful unlock: the same scan, then the mixer's multiply sequence, which dominates.
// A new request is taken in the cycle the result strobe is high; the receiver cannot stall.
// Synchronous active-low reset clears all sessions and the configuration registers.
`include "session_token_table_macros.svh"
module session_token_table #(
    parameter int SESSIONS = stt_pkg::SESSIONS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  stt_pkg::t_req              i_req,
    output logic                       o_res_valid,
    output stt_pkg::t_res              o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [stt_pkg::CFG_AW-1:0] paddr,
    input  logic [stt_pkg::CFG_DW-1:0] pwdata,
    output logic [stt_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);
    import stt_pkg::*;

    localparam int IDX_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

    t_cfg                cfg;
    t_state              r_state, n_state;
    t_req                r_req, n_req;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [IDX_W-1:0]    r_sel, n_sel;
    logic [SESSIONS-1:0] r_active, n_active;
    logic                r_found, n_found;
    logic                r_free, n_free;
    logic [31:0]         r_best, n_best;
    logic [31:0]         r_rem, n_rem;
    logic [63:0]         r_tok_out, n_tok_out;
    logic                r_res_valid, n_res_valid;
    t_res                r_res, n_res;

    logic [31:0]         mem_exp [SESSIONS];
    logic [63:0]         mem_tok [SESSIONS];
    logic [31:0]         r_exp_q;
    logic [63:0]         r_tok_q;
    logic                mem_we;
    logic [31:0]         new_exp;

    logic                mix_start;
    logic                mix_done;
    logic [63:0]         mix_out;

    logic                pin_ok;
    logic                unlock_ok;
    logic                slot_act;
    logic                slot_gone;
    logic                slot_live;
    logic                slot_last;
    logic [31:0]         elapsed;
    logic [31:0]         exp_diff;

    stt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    stt_mix #(
        .SESSIONS (SESSIONS)
    ) u_mix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mix_start),
        .i_entropy (r_req.entropy),
        .i_now     (r_req.now_ms),
        .i_slot    (r_sel),
        .o_done    (mix_done),
        .o_mix     (mix_out)
    );

    // Compare offered PIN against the configured one, bytes below the length only
    always_comb begin
        pin_ok = (i_req.pin_length == cfg.pin_code_len);
        for (int b = 0; b < PIN_CHARS; b++) begin
            if ((4'(b) < i_req.pin_length) &&
                (i_req.pin[8*b +: 8] != cfg.pin_code[8*b +: 8])) begin
                pin_ok = 1'b0;
            end
        end
    end

    assign unlock_ok = pin_ok && (cfg.session_timeout != 32'h0);

    // Classify the slot under check: wrap-safe expiry and earliest-expiry compare
    assign elapsed   = r_req.now_ms - r_exp_q;
    assign exp_diff  = r_exp_q - r_best;
    assign slot_act  = r_active[r_idx];
    assign slot_gone = !elapsed[31];
    assign slot_live = slot_act && !slot_gone;
    assign slot_last = (r_idx == IDX_W'(SESSIONS - 1));
    assign new_exp   = r_req.now_ms + cfg.session_timeout;

    // Sequence the slot scan, the token mix and the result
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_idx       = r_idx;
        n_sel       = r_sel;
        n_active    = r_active;
        n_found     = r_found;
        n_free      = r_free;
        n_best      = r_best;
        n_rem       = r_rem;
        n_tok_out   = r_tok_out;
        n_res_valid = 1'b0;
        n_res       = r_res;
        mix_start   = 1'b0;
        mem_we      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req     = i_req;
                    n_idx     = '0;
                    n_sel     = '0;
                    n_found   = 1'b0;
                    n_free    = 1'b0;
                    n_best    = '0;
                    n_rem     = '0;
                    n_tok_out = '0;
                    if ((i_req.action == ACT_UNLOCK) && !unlock_ok) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                // drop an expired session
                if (slot_act && slot_gone) begin
                    n_active[r_idx] = 1'b0;
                end
                case (r_req.action) inside
                    ACT_UNLOCK: begin
                        if (!r_free) begin
                            if (!slot_live) begin
                                n_free = 1'b1;
                                n_sel  = r_idx;
                            end else if ((r_idx == '0) || exp_diff[31]) begin
                                n_sel  = r_idx;
                                n_best = r_exp_q;
                            end
                        end
                    end
                    ACT_VALIDATE, ACT_REMAIN: begin
                        if (slot_live && (r_tok_q == r_req.token) && !r_found) begin
                            n_found = 1'b1;
                            if (r_req.action == ACT_REMAIN) begin
                                n_rem = r_exp_q - r_req.now_ms;
                            end
                        end
                    end
                    default: begin
                        if (slot_live) begin
                            n_found = 1'b1;
                        end
                    end
                endcase
                if (slot_last) begin
                    n_state = (r_req.action == ACT_UNLOCK) ? ST_MIX_GO : ST_DONE;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = ST_READ;
                end
            end
            ST_MIX_GO: begin
                mix_start = 1'b1;
                n_state   = ST_MIX_WAIT;
            end
            ST_MIX_WAIT: begin
                // write the new session into the chosen slot
                if (mix_done) begin
                    mem_we          = 1'b1;
                    n_active[r_sel] = 1'b1;
                    n_found         = 1'b1;
                    n_tok_out       = mix_out;
                    n_state         = ST_DONE;
                end
            end
            ST_DONE: begin
                n_res_valid      = 1'b1;
                n_res.ok         = r_found;
                n_res.token_out  = r_tok_out;
                n_res.remaining_ms = r_rem;
                n_state          = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_res_valid <= n_res_valid;
        end
    end

    // Hold request and scan payload
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_idx     <= n_idx;
        r_sel     <= n_sel;
        r_found   <= n_found;
        r_free    <= n_free;
        r_best    <= n_best;
        r_rem     <= n_rem;
        r_tok_out <= n_tok_out;
        r_res     <= n_res;
    end

    // Slot memories: one write port, registered read at the scan index
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_exp[r_sel] <= new_exp;
            mem_tok[r_sel] <= mix_out;
        end
        r_exp_q <= mem_exp[r_idx];
        r_tok_q <= mem_tok[r_idx];
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `STT_ASSERT_NEXT(a_strobe_single, o_res_valid, !o_res_valid)
    `STT_ASSERT_IMPLY(a_strobe_idle, o_res_valid, !busy)
    `STT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `STT_ASSERT_IMPLY(a_mix_in_wait, mix_done, r_state == ST_MIX_WAIT)

endmodule

FILE: src/stt_cfg.sv
// APB configuration registers of the session token table.
module stt_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [stt_pkg::CFG_AW-1:0] paddr,
    input  logic [stt_pkg::CFG_DW-1:0] pwdata,
    output logic [stt_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    output stt_pkg::t_cfg              o_cfg
);
    import stt_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Decode the write address and update one register
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (paddr[4:3])
                REG_PIN:     n_cfg.pin_code        = pwdata;
                REG_PIN_LEN: n_cfg.pin_code_len    = pwdata[3:0];
                REG_TIMEOUT: n_cfg.session_timeout = pwdata[31:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    // Hold the register values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Return the addressed register on reads
    always_comb begin
        unique case (paddr[4:3])
            REG_PIN:     prdata = r_cfg.pin_code;
            REG_PIN_LEN: prdata = {60'h0, r_cfg.pin_code_len};
            REG_TIMEOUT: prdata = {32'h0, r_cfg.session_timeout};
            default:     prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/stt_mix.sv
// Token mixer: splitmix64 finalizer on one shared 32x32 multiplier.
module stt_mix #(
    parameter int SESSIONS = stt_pkg::SESSIONS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_start,
    input  logic [63:0]                               i_entropy,
    input  logic [31:0]                               i_now,
    input  logic [((SESSIONS > 1) ? $clog2(SESSIONS) : 1)-1:0] i_slot,
    output logic                                      o_done,
    output logic [63:0]                               o_mix
);
    import stt_pkg::*;

    localparam int IDX_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

    t_mix_state  r_state, n_state;
    logic [1:0]  r_k, n_k;
    logic        r_done, n_done;
    logic [63:0] r_opa, n_opa;
    logic [63:0] r_seed, n_seed;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_mix, n_mix;
    logic [63:0] r_prod;
    logic [63:0] opb;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [63:0] sum;
    logic [63:0] gold_m;
    logic [63:0] slot_ext;
    logic [IDX_W:0] slot_inc;

    // Form slot number plus one as the golden-ratio multiplicand
    assign slot_inc = {1'b0, i_slot} + (IDX_W + 1)'(1);
    assign slot_ext = {{(63 - IDX_W){1'b0}}, slot_inc};

    // Pick the constant operand for the current multiply
    always_comb begin
        unique case (r_state)
            MX_GOLD: opb = MIX_GOLDEN;
            MX_MUL1: opb = MIX_MUL_A;
            default: opb = MIX_MUL_B;
        endcase
    end

    // Select the partial product halves for this cycle
    always_comb begin
        case (r_k)
            2'd0:    begin mul_a = r_opa[31:0];  mul_b = opb[31:0];  end
            2'd1:    begin mul_a = r_opa[31:0];  mul_b = opb[63:32]; end
            default: begin mul_a = r_opa[63:32]; mul_b = opb[31:0];  end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign sum    = r_acc + {r_prod[31:0], 32'h0};
    assign gold_m = r_seed ^ sum;

    // Sequence the three multiplies and the xor-shift steps
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_done  = 1'b0;
        n_opa   = r_opa;
        n_seed  = r_seed;
        n_acc   = r_acc;
        n_mix   = r_mix;
        if (r_state != MX_IDLE) begin
            n_k = r_k + 2'd1;
            case (r_k)
                2'd1:    n_acc = r_prod;
                2'd2:    n_acc = sum;
                default: n_acc = r_acc;
            endcase
        end
        unique case (r_state)
            MX_IDLE: begin
                if (i_start) begin
                    n_opa   = slot_ext;
                    n_seed  = i_entropy ^ {i_now, 32'h0};
                    n_k     = 2'd0;
                    n_state = MX_GOLD;
                end
            end
            MX_GOLD: begin
                if (r_k == 2'd3) begin
                    n_opa   = gold_m ^ (gold_m >> MIX_SH_A);
                    n_state = MX_MUL1;
                end
            end
            MX_MUL1: begin
                if (r_k == 2'd3) begin
                    n_opa   = sum ^ (sum >> MIX_SH_B);
                    n_state = MX_MUL2;
                end
            end
            MX_MUL2: begin
                if (r_k == 2'd3) begin
                    n_mix   = sum ^ (sum >> MIX_SH_C);
                    n_done  = 1'b1;
                    n_state = MX_IDLE;
                end
            end
            default: n_state = MX_IDLE;
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MX_IDLE;
            r_k     <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_done  <= n_done;
        end
    end

    // Register operands, product and accumulator
    always_ff @(posedge i_clk) begin
        r_opa  <= n_opa;
        r_seed <= n_seed;
        r_acc  <= n_acc;
        r_mix  <= n_mix;
        r_prod <= prod;
    end

    assign o_done = r_done;
    assign o_mix  = r_mix;

endmodule

FILE: tb/sv/session_token_table_checker.sv
// Checker for the session token table: predicts every reply and compares it with the block.
module session_token_table_checker
    import stt_pkg::*;
#(
    parameter int SESSIONS = SESSIONS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  t_req              i_req,
    input  logic              i_res_valid,
    input  t_res              i_res,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [CFG_AW-1:0] i_paddr,
    input  logic [CFG_DW-1:0] i_pwdata,
    input  logic              i_pready,
    output int                o_fail_count,
    output int                o_pending
);

    // Shadow copy of the session table and the configuration
    logic        slot_live     [SESSIONS];
    logic [31:0] slot_deadline [SESSIONS];
    logic [63:0] slot_tok      [SESSIONS];
    t_cfg        cfg_shadow;

    // Replies predicted for accepted requests, oldest first
    t_res        reply_queue [$];
    int          fail_total = 0;

    // Wrap-safe test of whether a deadline has been reached
    function automatic logic is_past(logic [31:0] now, logic [31:0] deadline);
        logic [31:0] gap;
        gap = now - deadline;
        return !gap[31];
    endfunction

    // Compare lengths in full and at most the first eight characters
    function automatic logic pin_ok(logic [63:0] offered, logic [3:0] offered_len);
        logic       same;
        logic [3:0] span;
        same = (offered_len == cfg_shadow.pin_code_len);
        span = (offered_len > 4'(PIN_CHARS)) ? 4'(PIN_CHARS) : offered_len;
        for (int i = 0; i < PIN_CHARS; i++) begin
            if (i < span && offered[i*8 +: 8] != cfg_shadow.pin_code[i*8 +: 8]) begin
                same = 1'b0;
            end
        end
        return same;
    endfunction

    // Drop every session whose deadline has been reached
    function automatic void purge_expired(logic [31:0] now);
        for (int i = 0; i < SESSIONS; i++) begin
            if (slot_live[i] && is_past(now, slot_deadline[i])) begin
                slot_live[i]     = 1'b0;
                slot_deadline[i] = '0;
                slot_tok[i]      = '0;
            end
        end
    endfunction

    // Lowest live slot holding the token, or -1
    function automatic int lookup_token(logic [63:0] tok);
        int hit;
        hit = -1;
        for (int i = SESSIONS - 1; i >= 0; i--) begin
            if (slot_live[i] && slot_tok[i] == tok) begin
                hit = i;
            end
        end
        return hit;
    endfunction

    // Finalizer over entropy, time and slot number
    function automatic logic [63:0] scramble_token(logic [63:0] seed, logic [31:0] now,
                                                   int slot);
        logic [63:0] m;
        m = seed ^ {now, 32'h0} ^ (MIX_GOLDEN * 64'(slot + 1));
        m = m ^ (m >> MIX_SH_A);
        m = m * MIX_MUL_A;
        m = m ^ (m >> MIX_SH_B);
        m = m * MIX_MUL_B;
        m = m ^ (m >> MIX_SH_C);
        return m;
    endfunction

    // Apply one request to the shadow table and return its reply
    function automatic t_res session_reply(t_req rq);
        t_res        r;
        int          pick;
        int          hit;
        logic        found;
        logic [31:0] gap;
        r = '0;
        case (rq.action)
            ACT_UNLOCK: begin
                if (cfg_shadow.session_timeout != '0 && pin_ok(rq.pin, rq.pin_length)) begin
                    purge_expired(rq.now_ms);
                    pick  = 0;
                    found = 1'b0;
                    // first free slot, else the one with the earliest deadline
                    for (int i = 0; i < SESSIONS; i++) begin
                        if (!found) begin
                            if (!slot_live[i]) begin
                                pick  = i;
                                found = 1'b1;
                            end else begin
                                gap = slot_deadline[i] - slot_deadline[pick];
                                if (gap[31]) pick = i;
                            end
                        end
                    end
                    slot_tok[pick]      = scramble_token(rq.entropy, rq.now_ms, pick);
                    slot_deadline[pick] = rq.now_ms + cfg_shadow.session_timeout;
                    slot_live[pick]     = 1'b1;
                    r.ok        = 1'b1;
                    r.token_out = slot_tok[pick];
                end
            end
            ACT_VALIDATE: begin
                purge_expired(rq.now_ms);
                r.ok = (lookup_token(rq.token) >= 0);
            end
            ACT_REMAIN: begin
                purge_expired(rq.now_ms);
                hit = lookup_token(rq.token);
                if (hit >= 0) begin
                    r.ok           = 1'b1;
                    r.remaining_ms = slot_deadline[hit] - rq.now_ms;
                end
            end
            ACT_ANY: begin
                purge_expired(rq.now_ms);
                for (int i = 0; i < SESSIONS; i++) begin
                    if (slot_live[i]) r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Watch the channels: compare replies, track register writes, predict requests
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            for (int i = 0; i < SESSIONS; i++) begin
                slot_live[i]     = 1'b0;
                slot_deadline[i] = '0;
                slot_tok[i]      = '0;
            end
            cfg_shadow = '0;
            reply_queue.delete();
        end else begin
            if (i_res_valid) begin
                if (reply_queue.size() == 0) begin
                    fail_total++;
                    $display("%0t: reply with no request pending: expected none, actual %h",
                             $time, i_res);
                end else begin
                    want = reply_queue.pop_front();
                    if (i_res.ok !== want.ok) begin
                        fail_total++;
                        $display("%0t: ok mismatch: expected %b, actual %b",
                                 $time, want.ok, i_res.ok);
                    end
                    if (i_res.token_out !== want.token_out) begin
                        fail_total++;
                        $display("%0t: token_out mismatch: expected %h, actual %h",
                                 $time, want.token_out, i_res.token_out);
                    end
                    if (i_res.remaining_ms !== want.remaining_ms) begin
                        fail_total++;
                        $display("%0t: remaining_ms mismatch: expected %h, actual %h",
                                 $time, want.remaining_ms, i_res.remaining_ms);
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr >> 3))
                    REG_PIN:     cfg_shadow.pin_code        = i_pwdata;
                    REG_PIN_LEN: cfg_shadow.pin_code_len    = i_pwdata[3:0];
                    REG_TIMEOUT: cfg_shadow.session_timeout = i_pwdata[31:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                reply_queue.push_back(session_reply(i_req));
            end
        end
        o_pending    <= reply_queue.size();
        o_fail_count <= fail_total;
    end

endmodule

FILE: tb/sv/tb_session_token_table.sv
// Testbench top for the session token table: clock, reset, stimulus and verdict.
module tb_session_token_table;
    import stt_pkg::*;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int ITEMS_PER_PHASE = 334;
    localparam int DRAIN_CYCLES    = 2 * SESSIONS_DEF + 24;

    localparam logic [CFG_AW-1:0] ADDR_PIN     = CFG_AW'(8 * int'(REG_PIN));
    localparam logic [CFG_AW-1:0] ADDR_PIN_LEN = CFG_AW'(8 * int'(REG_PIN_LEN));
    localparam logic [CFG_AW-1:0] ADDR_TIMEOUT = CFG_AW'(8 * int'(REG_TIMEOUT));

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    t_req              i_req   = '0;
    logic              o_res_valid;
    t_res              o_res;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [CFG_AW-1:0] paddr   = '0;
    logic [CFG_DW-1:0] pwdata  = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    int                fail_count;
    int                pending;
    int                cycle_count = 0;

    // Stimulus state: current time, programmed settings, tokens seen so far
    logic [31:0]       clock_ms;
    logic [63:0]       cur_pin;
    logic [3:0]        cur_len;
    logic [31:0]       cur_timeout;
    int                step_max;
    int                idle_pct;
    logic [63:0]       issued_tokens [$];

    session_token_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    session_token_table_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_res_valid  (o_res_valid),
        .i_res        (o_res),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Keep the most recent tokens handed out, for validate and remaining-time requests
    always @(posedge i_clk) begin
        if (o_res_valid && o_res.token_out != '0) begin
            issued_tokens.push_back(o_res.token_out);
            if (issued_tokens.size() > 8) void'(issued_tokens.pop_front());
        end
    end

    task automatic apb_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Program all three registers and pick a matching time step
    task automatic program_table(input logic [63:0] pin, input logic [3:0] len,
                                 input logic [31:0] timeout);
        cur_pin     = pin;
        cur_len     = len;
        cur_timeout = timeout;
        step_max    = (timeout == '0 || timeout > 32'd100000) ? 5000 : int'(timeout / 3) + 1;
        apb_write(ADDR_PIN, pin);
        apb_write(ADDR_PIN_LEN, CFG_DW'(len));
        apb_write(ADDR_TIMEOUT, CFG_DW'(timeout));
    endtask

    // Hold a request until the block takes it
    task automatic issue(input t_req rq);
        i_req <= rq;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start and wait for every reply to come back
    task automatic wait_drained;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
    endtask

    // Idle the sender for a random stretch
    task automatic pause_maybe;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    endtask

    // Advance time in small steps, with an occasional jump anywhere
    task automatic advance_clock;
        if ($urandom_range(99) < 2) clock_ms = $urandom;
        else clock_ms = clock_ms + 32'($urandom_range(0, step_max));
    endtask

    function automatic t_req req_of(t_action act, logic [31:0] now, logic [63:0] pin,
                                    logic [3:0] len, logic [63:0] tok);
        t_req rq;
        rq.action     = act;
        rq.now_ms     = now;
        rq.pin        = pin;
        rq.pin_length = len;
        rq.entropy    = {$urandom, $urandom};
        rq.token      = tok;
        return rq;
    endfunction

    // Correct PIN; bytes past the length are zero or junk
    function automatic logic [63:0] correct_pin(logic junk);
        logic [63:0] p;
        int          span;
        p    = {$urandom, $urandom};
        span = (cur_len > 4'(PIN_CHARS)) ? PIN_CHARS : int'(cur_len);
        for (int i = 0; i < PIN_CHARS; i++) begin
            if (i < span) p[i*8 +: 8] = cur_pin[i*8 +: 8];
            else if (!junk) p[i*8 +: 8] = 8'h00;
        end
        return p;
    endfunction

    // Mostly well-formed requests with random content, the rest noise
    function automatic t_req random_request();
        t_req rq;
        int   roll;
        int   pos;
        rq = req_of(t_action'($urandom_range(3)), clock_ms, {$urandom, $urandom},
                    4'($urandom_range(15)), {$urandom, $urandom});
        roll = $urandom_range(99);
        if (roll < 40) rq.action = ACT_UNLOCK;
        if (roll < 85) begin
            if (rq.action == ACT_UNLOCK) begin
                rq.pin        = correct_pin($urandom_range(99) < 30);
                rq.pin_length = cur_len;
                // break the PIN now and then: one byte or the length
                if ($urandom_range(99) < 12) begin
                    pos = $urandom_range(PIN_CHARS - 1);
                    rq.pin[pos*8 +: 8] = rq.pin[pos*8 +: 8] ^ 8'(1 << $urandom_range(7));
                end else if ($urandom_range(99) < 5) begin
                    rq.pin_length = cur_len ^ 4'(1 << $urandom_range(3));
                end
            end else if (issued_tokens.size() > 0 && $urandom_range(99) < 85) begin
                rq.token = issued_tokens[$urandom_range(issued_tokens.size() - 1)];
            end
        end
        return rq;
    endfunction

    initial begin
        logic [63:0] tok;
        logic [63:0] pin;
        clock_ms    = '0;
        cur_pin     = '0;
        cur_len     = '0;
        cur_timeout = '0;
        step_max    = 1;
        idle_pct    = 35;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // After reset: zero timeout refuses unlock, table is empty
        issue(req_of(ACT_UNLOCK, 32'd10, 64'h0, 4'd0, 64'h0));
        issue(req_of(ACT_ANY, 32'd20, 64'h0, 4'd0, 64'h0));
        issue(req_of(ACT_VALIDATE, 32'd30, 64'h0, 4'd0, 64'h0));
        wait_drained();

        // Eight-character PIN with a zero byte inside it
        program_table(64'h8877_0066_5544_3322, 4'd8, 32'd1000);
        issue(req_of(ACT_UNLOCK, 32'd100, cur_pin, 4'd8, 64'h0));
        issue(req_of(ACT_UNLOCK, 32'd110, cur_pin, 4'd7, 64'h0));
        issue(req_of(ACT_UNLOCK, 32'd120, cur_pin ^ 64'h0100_0000_0000_0000, 4'd8, 64'h0));
        issue(req_of(ACT_UNLOCK, 32'd130, cur_pin ^ 64'h1, 4'd8, 64'h0));
        wait_drained();
        tok = issued_tokens[$];
        issue(req_of(ACT_VALIDATE, 32'd300, 64'h0, 4'd0, tok));
        issue(req_of(ACT_REMAIN, 32'd400, 64'h0, 4'd0, tok));
        issue(req_of(ACT_VALIDATE, 32'd410, 64'h0, 4'd0, ~tok));
        issue(req_of(ACT_ANY, 32'd420, 64'h0, 4'd0, 64'h0));
        // Fill every slot, then reuse the one with the earliest deadline
        issue(req_of(ACT_UNLOCK, 32'd500, cur_pin, 4'd8, 64'h0));
        issue(req_of(ACT_UNLOCK, 32'd600, cur_pin, 4'd8, 64'h0));
        issue(req_of(ACT_UNLOCK, 32'd700, cur_pin, 4'd8, 64'h0));
        issue(req_of(ACT_UNLOCK, 32'd800, cur_pin, 4'd8, 64'h0));
        issue(req_of(ACT_REMAIN, 32'd1100, 64'h0, 4'd0, tok));
        issue(req_of(ACT_ANY, 32'd2000, 64'h0, 4'd0, 64'h0));
        wait_drained();

        // Length above eight: only the first eight bytes count
        program_table({$urandom, $urandom}, 4'd12, 32'd500);
        issue(req_of(ACT_UNLOCK, 32'd3000, cur_pin, 4'd12, 64'h0));
        issue(req_of(ACT_UNLOCK, 32'd3010, cur_pin, 4'd4, 64'h0));
        wait_drained();

        // Largest timeout: the deadline lands just behind now
        program_table(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'hFFFF_FFFF);
        issue(req_of(ACT_UNLOCK, 32'd5000, {$urandom, $urandom}, 4'd0, 64'h0));
        issue(req_of(ACT_ANY, 32'd5000, 64'h0, 4'd0, 64'h0));
        wait_drained();

        // Deadline that wraps past zero
        program_table(64'h0, 4'd0, 32'd1000);
        issue(req_of(ACT_UNLOCK, 32'hFFFF_FF00, 64'h0, 4'd0, 64'h0));
        wait_drained();
        tok = issued_tokens[$];
        issue(req_of(ACT_REMAIN, 32'h0000_0100, 64'h0, 4'd0, tok));
        issue(req_of(ACT_ANY, 32'h0000_0300, 64'h0, 4'd0, 64'h0));
        wait_drained();

        // Random phases over several settings, sender idling 35, then 68, then never
        clock_ms = $urandom;
        for (int ph = 0; ph < 6; ph++) begin
            pin = {$urandom, $urandom};
            case (ph)
                0: program_table(pin, 4'd8, 32'd1000);
                1: program_table(pin, 4'd4, 32'd1);
                2: program_table(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'hFFFF_FFFF);
                3: program_table(pin, 4'd3, 32'h8000_0000);
                4: program_table(64'h0, 4'd1, 32'd300);
                default: program_table(pin, 4'd8, 32'd5000);
            endcase
            idle_pct = (ph < 2) ? 35 : (ph < 4) ? 68 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                advance_clock();
                issue(random_request());
                pause_maybe();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/stt_pkg.sv
src/stt_cfg.sv
src/stt_mix.sv
src/session_token_table.sv
tb/sv/session_token_table_checker.sv
tb/sv/tb_session_token_table.sv
